[design/erm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_pkg
// Shared types, constants and the arctangent table for the rotation matrix.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int CORDIC_STAGES  = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int ANGLE_W        = 18;
  localparam int OUT_W          = 18;
  localparam int Q              = 30;
  localparam int XW             = 34;   // CORDIC x/y datapath
  localparam int ZW             = 33;   // CORDIC phase accumulator
  localparam int PW             = 32;   // reduced phase
  localparam int PROD_W         = 52;   // angle times phase scale
  localparam int PROD_LAT       = 2;    // phase multiply pipeline depth
  localparam int MUL_LAT        = 3;    // matrix product depth after CORDIC
  localparam int PIPE_LAT       = PROD_LAT + 1 + CORDIC_STAGES + 1 + MUL_LAT + 1;
  localparam int STAGE_W        = $clog2(CORDIC_STAGES);  // cell stage index

  localparam logic [31:0] RAD_TO_PHASE = 32'd2734261102;
  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
  localparam logic signed [XW-1:0] ONE_Q       = XW'(64'sd1 << Q);

  typedef logic signed [XW-1:0]      q_t;
  typedef logic signed [ZW-1:0]      ph_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [OUT_W-1:0]   coef_t;

  // one CORDIC lane as it travels from cell to cell
  typedef struct packed {
    q_t   x;
    q_t   y;
    ph_t  z;
    logic flip;
  } cord_t;

  function automatic ph_t atan_phase(input int i);
    unique case (i)
      0:  atan_phase = ZW'(536870912);
      1:  atan_phase = ZW'(316933406);
      2:  atan_phase = ZW'(167458907);
      3:  atan_phase = ZW'(85004756);
      4:  atan_phase = ZW'(42667331);
      5:  atan_phase = ZW'(21354465);
      6:  atan_phase = ZW'(10679838);
      7:  atan_phase = ZW'(5340245);
      8:  atan_phase = ZW'(2670163);
      9:  atan_phase = ZW'(1335087);
      10: atan_phase = ZW'(667544);
      11: atan_phase = ZW'(333772);
      12: atan_phase = ZW'(166886);
      13: atan_phase = ZW'(83443);
      14: atan_phase = ZW'(41722);
      15: atan_phase = ZW'(20861);
      16: atan_phase = ZW'(10430);
      17: atan_phase = ZW'(5215);
      18: atan_phase = ZW'(2608);
      19: atan_phase = ZW'(1304);
      20: atan_phase = ZW'(652);
      21: atan_phase = ZW'(326);
      22: atan_phase = ZW'(163);
      23: atan_phase = ZW'(81);
      default: atan_phase = '0;
    endcase
  endfunction

  // Q30 product with round half up
  function automatic q_t qmul(input q_t u, input q_t v);
    logic signed [2*XW-1:0] p;
    p = (2*XW)'(u) * (2*XW)'(v) + (2*XW)'(64'sd1 <<< (Q - 1));
    qmul = XW'(p >>> Q);
  endfunction

  function automatic q_t clamp_one(input q_t v);
    if (v > ONE_Q)       clamp_one = ONE_Q;
    else if (v < -ONE_Q) clamp_one = -ONE_Q;
    else                 clamp_one = v;
  endfunction

  // Q30 to output field
  function automatic coef_t to_out(input q_t v);
    localparam int SH = Q - COEF_FRAC_BITS;
    localparam logic signed [XW-1:0] LIM = XW'(64'sd1 << COEF_FRAC_BITS);
    q_t r;
    if (SH > 0) r = (v + XW'(64'sd1 << (SH > 0 ? SH - 1 : 0))) >>> SH;
    else        r = v;
    if (r > LIM)       r = LIM;
    else if (r < -LIM) r = -LIM;
    to_out = r[OUT_W-1:0];
  endfunction

endpackage

[design/erm_cordic_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_cordic_cell
// One CORDIC rotation step, registered, for a fixed stage index.
// ----------------------------------------------------------------------------
module erm_cordic_cell import erm_pkg::*; (
  input  logic               clk,
  input  logic [STAGE_W-1:0] stage,   // tied to a constant per cell
  input  cord_t              cell_in,
  output cord_t              cell_out
);

  cord_t cell_nxt;
  cord_t cell_r;

  always_comb begin
    cell_nxt = cell_in;
    if (!cell_in.z[ZW-1]) begin
      cell_nxt.x = cell_in.x - (cell_in.y >>> stage);
      cell_nxt.y = cell_in.y + (cell_in.x >>> stage);
      cell_nxt.z = cell_in.z - atan_phase(int'(stage));
    end else begin
      cell_nxt.x = cell_in.x + (cell_in.y >>> stage);
      cell_nxt.y = cell_in.y - (cell_in.x >>> stage);
      cell_nxt.z = cell_in.z + atan_phase(int'(stage));
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_out = cell_r;

endmodule

[design/erm_sincos.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_sincos
// Angle to phase, quadrant fold, chain of CORDIC cells, sign fix and clamp.
// ----------------------------------------------------------------------------
module erm_sincos import erm_pkg::*; (
  input  logic   clk,
  input  angle_t angle,
  output q_t     sin_q,
  output q_t     cos_q
);

  logic signed [PROD_W-1:0] prod_r [PROD_LAT];
  cord_t                    fold_r;
  cord_t                    chain [CORDIC_STAGES+1];
  q_t                       sin_r, cos_r;
  logic [PW-1:0]            ph;
  logic signed [ZW-1:0]     zs;
  cord_t                    fold_nxt;

  always_ff @(posedge clk) begin
    prod_r[0] <= PROD_W'(angle) * $signed({1'b0, RAD_TO_PHASE});
    for (int i = 1; i < PROD_LAT; i++) prod_r[i] <= prod_r[i-1];
  end

  always_comb begin
    ph = PW'((prod_r[PROD_LAT-1] + PROD_W'(32768)) >>> 16);
    zs = ZW'($signed(ph));
    fold_nxt.x = CORDIC_GAIN;
    fold_nxt.y = '0;
    fold_nxt.flip = 1'b0;
    fold_nxt.z = zs;
    if (zs > ZW'(33'sh40000000)) begin
      fold_nxt.z = zs - ZW'(33'sh80000000);
      fold_nxt.flip = 1'b1;
    end else if (zs < -ZW'(33'sh40000000)) begin
      fold_nxt.z = zs + ZW'(33'sh80000000);
      fold_nxt.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    fold_r <= fold_nxt;
  end

  assign chain[0] = fold_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    erm_cordic_cell u_cell (
      .clk      (clk),
      .stage    (STAGE_W'(g)),
      .cell_in  (chain[g]),
      .cell_out (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (chain[CORDIC_STAGES].flip) begin
      cos_r <= clamp_one(-chain[CORDIC_STAGES].x);
      sin_r <= clamp_one(-chain[CORDIC_STAGES].y);
    end else begin
      cos_r <= clamp_one(chain[CORDIC_STAGES].x);
      sin_r <= clamp_one(chain[CORDIC_STAGES].y);
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

[design/euler_rotation_matrix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_rotation_matrix
// Z*Y*X rotation matrix from three Q14 radian angles via pipelined CORDIC.
// ----------------------------------------------------------------------------
// Fully pipelined: a new beat is taken on every clock (busy is tied low) and
// its matrix appears on out_* with out_valid high for one cycle, after the
// PIPE_LAT register stages (2 phase multiply, 1 fold, 16 CORDIC cells,
// 1 sign/clamp, 3 product, 1 output). Most of the depth is the CORDIC cell
// chain. The receiver cannot stall; results must be taken as they appear.
// planar_mode is sampled together with the angles, so it should only be
// written while no beat is in flight.
// ----------------------------------------------------------------------------
module euler_rotation_matrix import erm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cfg_we,
  input  logic   cfg_wdata,
  input  logic   start,
  output logic   busy,
  input  angle_t in_angle_roll,
  input  angle_t in_angle_pitch,
  input  angle_t in_angle_yaw,
  output logic   out_valid,
  output coef_t  out_m00,
  output coef_t  out_m01,
  output coef_t  out_m02,
  output coef_t  out_m10,
  output coef_t  out_m11,
  output coef_t  out_m12,
  output coef_t  out_m20,
  output coef_t  out_m21,
  output coef_t  out_m22
);

  logic planar_r;
  logic [PIPE_LAT-1:0] vld_r;
  logic [PIPE_LAT-2:0] mode_r;
  q_t sa, ca, sb, cb, sy, cy;

  // product stage 1
  q_t casb_r, sasb_r, cacb_r, sacb_r, sacy_r, sasy_r, cacy_r, casy_r;
  q_t cbsy_r, cbcy_r, nsb1_r, sy1_r, cy1_r, sa1_r, ca1_r;
  // product stage 2
  q_t p0_r, p3_r, p6_r, p7_r, p8_r, t1_r, t2_r, t4_r, t5_r;
  q_t u1_r, u2_r, u4_r, u5_r, sa2_r, ca2_r;
  // sums
  q_t m_r [9];
  q_t m_sel [9];
  coef_t o_r [9];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planar_r <= 1'b0;
      vld_r    <= '0;
    end else begin
      if (cfg_we) planar_r <= cfg_wdata;
      vld_r <= {vld_r[PIPE_LAT-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= {mode_r[PIPE_LAT-3:0], planar_r};
  end

  erm_sincos u_roll  (.clk(clk), .angle(in_angle_roll),  .sin_q(sa), .cos_q(ca));
  erm_sincos u_pitch (.clk(clk), .angle(in_angle_pitch), .sin_q(sb), .cos_q(cb));
  erm_sincos u_yaw   (.clk(clk), .angle(in_angle_yaw),   .sin_q(sy), .cos_q(cy));

  always_ff @(posedge clk) begin
    casb_r <= qmul(ca, sb);  sasb_r <= qmul(sa, sb);
    cacb_r <= qmul(ca, cb);  sacb_r <= qmul(sa, cb);
    sacy_r <= qmul(sa, cy);  sasy_r <= qmul(sa, sy);
    cacy_r <= qmul(ca, cy);  casy_r <= qmul(ca, sy);
    cbsy_r <= qmul(cb, sy);  cbcy_r <= qmul(cb, cy);
    nsb1_r <= -sb; sy1_r <= sy; cy1_r <= cy; sa1_r <= sa; ca1_r <= ca;

    t1_r <= qmul(casb_r, sy1_r);  u1_r <= sacy_r;
    t2_r <= qmul(casb_r, cy1_r);  u2_r <= sasy_r;
    t4_r <= qmul(sasb_r, sy1_r);  u4_r <= cacy_r;
    t5_r <= qmul(sasb_r, cy1_r);  u5_r <= casy_r;
    p0_r <= cacb_r; p3_r <= sacb_r; p6_r <= nsb1_r; p7_r <= cbsy_r; p8_r <= cbcy_r;
    sa2_r <= sa1_r; ca2_r <= ca1_r;

    // planar mode: upper-left 2x2 block straight from roll sine and cosine
    m_r[0] <= mode_r[PIPE_LAT-3] ?  ca2_r : p0_r;
    m_r[1] <= mode_r[PIPE_LAT-3] ? -sa2_r : t1_r - u1_r;
    m_r[2] <= t2_r + u2_r;
    m_r[3] <= mode_r[PIPE_LAT-3] ?  sa2_r : p3_r;
    m_r[4] <= mode_r[PIPE_LAT-3] ?  ca2_r : t4_r + u4_r;
    m_r[5] <= t5_r - u5_r;
    m_r[6] <= p6_r;           m_r[7] <= p7_r;         m_r[8] <= p8_r;
  end

  // planar mode: constant row and column
  always_comb begin
    for (int k = 0; k < 9; k++) m_sel[k] = m_r[k];
    if (mode_r[PIPE_LAT-2]) begin
      m_sel[2] = '0; m_sel[5] = '0; m_sel[6] = '0; m_sel[7] = '0;
      m_sel[8] = ONE_Q;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) o_r[k] <= to_out(m_sel[k]);
  end

  assign out_valid = vld_r[PIPE_LAT-1];
  assign out_m00 = o_r[0];
  assign out_m01 = o_r[1];
  assign out_m02 = o_r[2];
  assign out_m10 = o_r[3];
  assign out_m11 = o_r[4];
  assign out_m12 = o_r[5];
  assign out_m20 = o_r[6];
  assign out_m21 = o_r[7];
  assign out_m22 = o_r[8];

endmodule

[tb/tb_euler_rotation_matrix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_rotation_matrix
// Self-checking bench for the Euler angle rotation matrix block.
// ----------------------------------------------------------------------------
// Each accepted angle beat is run through a bit-exact CORDIC and product
// model here, and its nine coefficients are queued. A monitor compares every
// out_valid beat against the oldest queued matrix. Tests cover the angle
// extremes, the quadrant fold points, both modes, and random angle traffic
// under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_euler_rotation_matrix;
  import erm_pkg::*;

  localparam int  WATCHDOG_LIMIT = 2000;
  localparam int  DRAIN_CYCLES   = PIPE_LAT + 8;

  // angle to phase scale, round(2^33/pi)
  localparam longint PHASE_SCALE = 64'd2734261102;
  localparam longint GAIN_Q30    = 64'd652032874;
  localparam longint UNIT_Q30    = 64'sd1 << 30;

  typedef struct packed {
    coef_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  logic   cfg_wdata;
  logic   start;
  logic   busy;
  angle_t in_angle_roll;
  angle_t in_angle_pitch;
  angle_t in_angle_yaw;
  logic   out_valid;
  coef_t  out_m00, out_m01, out_m02, out_m10, out_m11, out_m12, out_m20, out_m21, out_m22;

  matrix_t pending_matrices[$];
  int      mismatch_count;
  int      idle_cycles;
  bit      planar_cfg;
  int      sender_idle_pct;

  euler_rotation_matrix uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy),
    .in_angle_roll(in_angle_roll), .in_angle_pitch(in_angle_pitch),
    .in_angle_yaw(in_angle_yaw), .out_valid(out_valid),
    .out_m00(out_m00), .out_m01(out_m01), .out_m02(out_m02),
    .out_m10(out_m10), .out_m11(out_m11), .out_m12(out_m12),
    .out_m20(out_m20), .out_m21(out_m21), .out_m22(out_m22)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic longint arctan_step(input int i);
    longint tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                        21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                        333772, 166886, 83443, 41722, 20861, 10430, 5215,
                        2608, 1304, 652, 326, 163, 81};
    return tbl[i];
  endfunction

  function automatic longint clamp_unit(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // sine and cosine of a Q14 radian angle, both Q30
  task automatic sine_cosine(input angle_t a, output longint sn, output longint cs);
    longint     prod;
    logic [63:0] pbits;
    logic [31:0] phase;
    longint     z, x, y, dx, dy;
    bit         flip;
    prod  = longint'(a) * PHASE_SCALE;
    pbits = prod + 64'd32768;
    phase = pbits[47:16];
    z     = longint'($signed(phase));
    flip  = 1'b0;
    x     = GAIN_Q30;
    y     = 0;
    if (z > 64'sh40000000) begin
      z = z - 64'sh80000000; flip = 1'b1;
    end else if (z < -64'sh40000000) begin
      z = z + 64'sh80000000; flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - arctan_step(i);
      end else begin
        x = x + dx; y = y - dy; z = z + arctan_step(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cs = clamp_unit(x, UNIT_Q30);
    sn = clamp_unit(y, UNIT_Q30);
  endtask

  function automatic longint mul_q30(input longint u, input longint v);
    return (u * v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic coef_t coef_field(input longint v);
    int sh;
    sh = 30 - COEF_FRAC_BITS;
    if (sh > 0) v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    v = clamp_unit(v, 64'sd1 <<< COEF_FRAC_BITS);
    return coef_t'(v);
  endfunction

  task automatic predict_matrix(input angle_t ar, input angle_t ap, input angle_t ay,
                                output matrix_t mx);
    longint sa, ca, sb, cb, sy, cy, casb, sasb;
    longint m[9];
    sine_cosine(ar, sa, ca);
    if (planar_cfg) begin
      m = '{ca, -sa, 0, sa, ca, 0, 0, 0, UNIT_Q30};
    end else begin
      sine_cosine(ap, sb, cb);
      sine_cosine(ay, sy, cy);
      casb = mul_q30(ca, sb);
      sasb = mul_q30(sa, sb);
      m[0] = mul_q30(ca, cb);
      m[1] = mul_q30(casb, sy) - mul_q30(sa, cy);
      m[2] = mul_q30(casb, cy) + mul_q30(sa, sy);
      m[3] = mul_q30(sa, cb);
      m[4] = mul_q30(sasb, sy) + mul_q30(ca, cy);
      m[5] = mul_q30(sasb, cy) - mul_q30(ca, sy);
      m[6] = -sb;
      m[7] = mul_q30(cb, sy);
      m[8] = mul_q30(cb, cy);
    end
    mx = '{coef_field(m[0]), coef_field(m[1]), coef_field(m[2]),
           coef_field(m[3]), coef_field(m[4]), coef_field(m[5]),
           coef_field(m[6]), coef_field(m[7]), coef_field(m[8])};
  endtask

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------

  // one beat; random idle cycles ahead of it per the current idle rate.
  // start is left high on return so the next beat can follow back to back;
  // the caller drops it when it stops sending.
  task automatic send_angles(input angle_t ar, input angle_t ap, input angle_t ay);
    matrix_t mx;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_angle_roll  <= ar;
    in_angle_pitch <= ap;
    in_angle_yaw   <= ay;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_matrix(ar, ap, ay, mx);
    pending_matrices.push_back(mx);
    @(negedge clk);
  endtask

  // let the pipe empty, then write planar_mode while nothing is in flight
  task automatic write_mode(input bit mode);
    start <= 1'b0;
    while (pending_matrices.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    planar_cfg = mode;
  endtask

  function automatic angle_t rand_angle();
    return angle_t'($urandom_range(18'h3FFFF));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_spatial_directed();
    angle_t corners[8] = '{18'sh1FFFF, -18'sh20000, 18'sd0, 18'sd1, -18'sd1,
                           18'sd25736, -18'sd25736, 18'sd12868};
    sender_idle_pct = 0;
    for (int i = 0; i < 8; i++)
      send_angles(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]);
    send_angles(18'sh15555, 18'sh2AAAA, 18'sh0FFFF);
  endtask

  // pitch and yaw carry junk that planar mode must ignore
  task automatic test_planar_directed();
    write_mode(1'b1);
    send_angles(18'sd0, 18'sh1FFFF, -18'sh20000);
    send_angles(18'sh1FFFF, 18'sd12345, 18'sd1);
    send_angles(-18'sh20000, -18'sd1, 18'sd0);
    send_angles(18'sd12868, 18'sh2AAAA, 18'sh15555);
    send_angles(-18'sd12868, 18'sd0, 18'sd0);
    send_angles(18'sd25736, rand_angle(), rand_angle());
  endtask

  task automatic test_random_traffic(input bit mode, input int idle_pct, input int beats);
    write_mode(mode);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < beats; i++) begin
      // hold off once mid-phase until the pipe has drained
      if (i == beats / 2) begin
        start <= 1'b0;
        while (pending_matrices.size() != 0) @(negedge clk);
      end
      send_angles(rand_angle(), rand_angle(), rand_angle());
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: compares each out_valid beat with the oldest expectation
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input coef_t got, input coef_t want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    matrix_t want;
    if (rst_n && out_valid) begin
      if (pending_matrices.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: unexpected result beat", $realtime);
      end else begin
        want = pending_matrices.pop_front();
        check_field("m00", out_m00, want.m00);
        check_field("m01", out_m01, want.m01);
        check_field("m02", out_m02, want.m02);
        check_field("m10", out_m10, want.m10);
        check_field("m11", out_m11, want.m11);
        check_field("m12", out_m12, want.m12);
        check_field("m20", out_m20, want.m20);
        check_field("m21", out_m21, want.m21);
        check_field("m22", out_m22, want.m22);
      end
    end
  end

  // watchdog: cycles with neither an input nor a result beat
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    planar_cfg      = 1'b0;
    sender_idle_pct = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    start          = 1'b0;
    in_angle_roll  = '0;
    in_angle_pitch = '0;
    in_angle_yaw   = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_spatial_directed();
    test_planar_directed();
    test_random_traffic(1'b0, 0, 200);
    test_random_traffic(1'b1, 72, 120);
    test_random_traffic(1'b0, 72, 150);
    test_random_traffic(1'b1, 36, 120);
    test_random_traffic(1'b0, 36, 160);

    start <= 1'b0;
    while (pending_matrices.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
